### rtl/htt_pkg.sv
`timescale 1ns / 1ps
package htt_pkg;

	localparam int POOL_DEPTH  = 1024;
	localparam int FRAME_DEPTH = 256;
	localparam int MAP_DEPTH   = 2048;
	localparam int KIND_COUNT  = 4;
	localparam int KIND_SHIFT  = 28;

	localparam int TOKEN_W  = 32;
	localparam int KCODE_W  = TOKEN_W - KIND_SHIFT;
	localparam int VALUE_W  = 64;
	localparam int COUNT_W  = 11;
	localparam int MARK_W   = 9;

	localparam int IDX_W    = $clog2(POOL_DEPTH);
	localparam int CNT_W    = $clog2(POOL_DEPTH) + 1;
	localparam int KSEL_W   = $clog2(KIND_COUNT);
	localparam int SLOT_AW  = KSEL_W + IDX_W;
	localparam int SLOT_W   = VALUE_W + 1;
	localparam int FRAME_AW = $clog2(FRAME_DEPTH);
	localparam int FDEP_W   = FRAME_AW + 1;
	localparam int MAP_AW   = $clog2(MAP_DEPTH);
	localparam int MAP_W    = VALUE_W + IDX_W;
	localparam int PAD_W    = KIND_SHIFT - IDX_W;

	// hash: only the low bits of the product reach the table index
	localparam logic [VALUE_W-1:0] HASH_MULT = 64'hff51afd7ed558ccd;
	localparam int HASH_SH = 33;
	localparam int ACC_W   = HASH_SH + MAP_AW;
	localparam int LO_W    = ACC_W / 2;
	localparam int HI_W    = ACC_W - LO_W;
	localparam logic [HI_W-1:0] HASH_C_LO = HI_W'(HASH_MULT[LO_W-1:0]);
	localparam logic [HI_W-1:0] HASH_C_HI = HASH_MULT[ACC_W-1:LO_W];

	localparam logic [2:0] OP_NEW_REF    = 3'd0;
	localparam logic [2:0] OP_RESOLVE    = 3'd1;
	localparam logic [2:0] OP_DELETE     = 3'd2;
	localparam logic [2:0] OP_INTERN     = 3'd3;
	localparam logic [2:0] OP_ID_DESC    = 3'd4;
	localparam logic [2:0] OP_FRAME_MARK = 3'd5;
	localparam logic [2:0] OP_FRAME_POP  = 3'd6;
	localparam logic [2:0] OP_LIVE_COUNT = 3'd7;

	localparam logic [KCODE_W-1:0] KIND_LOCAL = 4'd1;
	localparam logic [KCODE_W-1:0] KIND_WEAK  = 4'd3;
	localparam logic [KCODE_W-1:0] KIND_ID    = 4'd4;

	localparam logic [4:0] UOP_NOP        = 5'd0;
	localparam logic [4:0] UOP_LOAD       = 5'd1;
	localparam logic [4:0] UOP_CLEAR      = 5'd2;
	localparam logic [4:0] UOP_HASH1      = 5'd3;
	localparam logic [4:0] UOP_HASH2      = 5'd4;
	localparam logic [4:0] UOP_HASH3      = 5'd5;
	localparam logic [4:0] UOP_PROBE_RD   = 5'd6;
	localparam logic [4:0] UOP_PROBE_STEP = 5'd7;
	localparam logic [4:0] UOP_MAP_HIT    = 5'd8;
	localparam logic [4:0] UOP_FREE_RD    = 5'd9;
	localparam logic [4:0] UOP_TAKE       = 5'd10;
	localparam logic [4:0] UOP_TOK_RD     = 5'd11;
	localparam logic [4:0] UOP_TOK_USE    = 5'd12;
	localparam logic [4:0] UOP_POP_RD     = 5'd13;
	localparam logic [4:0] UOP_POP_CHK    = 5'd14;
	localparam logic [4:0] UOP_POP_USE    = 5'd15;
	localparam logic [4:0] UOP_DONE       = 5'd16;

	typedef struct packed {
		logic [2:0]         opcode;
		logic [3:0]         ref_kind;
		logic [VALUE_W-1:0] ref_value;
		logic [VALUE_W-1:0] descriptor;
		logic [TOKEN_W-1:0] token_in;
		logic [MARK_W-1:0]  pop_mark;
	} req_t;

	typedef struct packed {
		logic [TOKEN_W-1:0] token_out;
		logic [VALUE_W-1:0] value_out;
		logic               deleted;
		logic [COUNT_W-1:0] count_out;
	} rsp_t;

	typedef struct packed {
		logic [4:0] uop;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       new_ok;
		logic       intern_ok;
		logic       tok_ok;
		logic       can_free;
		logic       can_fresh;
		logic       map_empty;
		logic       map_match;
		logic       pop_more;
		logic       clr_last;
	} stat_t;

endpackage

### rtl/htt_ram.sv
`timescale 1ns / 1ps
module htt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/htt_ctrl.sv
`timescale 1ns / 1ps
module htt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  htt_pkg::stat_t stat,
	output htt_pkg::cmd_t  cmd,
	output logic          busy
);
	import htt_pkg::*;

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_DISP   = 4'd2;
	localparam logic [3:0] S_H2     = 4'd3;
	localparam logic [3:0] S_H3     = 4'd4;
	localparam logic [3:0] S_PRD    = 4'd5;
	localparam logic [3:0] S_PCHK   = 4'd6;
	localparam logic [3:0] S_TAKE   = 4'd7;
	localparam logic [3:0] S_TOKUSE = 4'd8;
	localparam logic [3:0] S_POP    = 4'd9;
	localparam logic [3:0] S_PWAIT  = 4'd10;
	localparam logic [3:0] S_PUSE   = 4'd11;
	localparam logic [3:0] S_DONE   = 4'd12;

	logic [3:0] state_q, state_d;
	logic [4:0] uop;

	always_comb begin
		state_d = state_q;
		uop     = UOP_NOP;
		case (state_q)
			S_CLEAR: begin
				uop = UOP_CLEAR;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					uop     = UOP_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_DONE;
				case (stat.op)
					OP_NEW_REF: begin
						if (stat.new_ok && stat.can_free) begin
							uop     = UOP_FREE_RD;
							state_d = S_TAKE;
						end else if (stat.new_ok && stat.can_fresh) begin
							state_d = S_TAKE;
						end
					end
					OP_RESOLVE, OP_DELETE, OP_ID_DESC: begin
						if (stat.tok_ok) begin
							uop     = UOP_TOK_RD;
							state_d = S_TOKUSE;
						end
					end
					OP_INTERN: begin
						if (stat.intern_ok) begin
							uop     = UOP_HASH1;
							state_d = S_H2;
						end
					end
					OP_FRAME_POP: state_d = S_POP;
					default: state_d = S_DONE;
				endcase
			end
			S_H2: begin
				uop     = UOP_HASH2;
				state_d = S_H3;
			end
			S_H3: begin
				uop     = UOP_HASH3;
				state_d = S_PRD;
			end
			S_PRD: begin
				uop     = UOP_PROBE_RD;
				state_d = S_PCHK;
			end
			S_PCHK: begin
				if (stat.map_match) begin
					uop     = UOP_MAP_HIT;
					state_d = S_DONE;
				end else if (stat.map_empty) begin
					if (stat.can_free) begin
						uop     = UOP_FREE_RD;
						state_d = S_TAKE;
					end else if (stat.can_fresh) begin
						state_d = S_TAKE;
					end else begin
						state_d = S_DONE;
					end
				end else begin
					uop = UOP_PROBE_STEP;
				end
			end
			S_TAKE: begin
				uop     = UOP_TAKE;
				state_d = S_DONE;
			end
			S_TOKUSE: begin
				uop     = UOP_TOK_USE;
				state_d = S_DONE;
			end
			S_POP: begin
				if (stat.pop_more) begin
					uop     = UOP_POP_RD;
					state_d = S_PWAIT;
				end else begin
					state_d = S_DONE;
				end
			end
			S_PWAIT: begin
				uop     = UOP_POP_CHK;
				state_d = S_PUSE;
			end
			S_PUSE: begin
				uop     = UOP_POP_USE;
				state_d = S_POP;
			end
			S_DONE: begin
				uop     = UOP_DONE;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.uop = uop;
	assign busy    = (state_q != S_IDLE);

endmodule

### rtl/htt_dpath.sv
`timescale 1ns / 1ps
module htt_dpath (
	input  logic          clk,
	input  logic          arst_n,
	input  htt_pkg::req_t  req,
	input  htt_pkg::cmd_t  cmd,
	output htt_pkg::stat_t stat,
	output htt_pkg::rsp_t  rsp,
	output logic          done
);
	import htt_pkg::*;

	req_t               req_q;
	rsp_t               rsp_q;
	logic [CNT_W-1:0]   hw_q   [KIND_COUNT];
	logic [CNT_W-1:0]   fd_q   [KIND_COUNT];
	logic [CNT_W-1:0]   live_q [KIND_COUNT];
	logic [FDEP_W-1:0]  fdepth_q;
	logic [MAP_AW-1:0]  clr_q;
	logic [MAP_AW-1:0]  h_q;
	logic [ACC_W-1:0]   acc_q;
	logic               from_free_q;
	logic               pop_ok_q;
	logic               done_q;
	logic [IDX_W-1:0]   pop_idx_q;

	logic [4:0]         uop;
	logic [2:0]         op;
	logic [KSEL_W-1:0]  pool_k;
	logic [KCODE_W-1:0] tk;
	logic [KIND_SHIFT-1:0] ti;
	logic [KSEL_W-1:0]  tok_k;
	logic [IDX_W-1:0]   tok_idx;
	logic               kind_ok;
	logic [IDX_W-1:0]   take_idx;
	logic [VALUE_W-1:0] xs;
	logic [HI_W-1:0]    mul_a, mul_b;
	logic [2*HI_W-1:0]  prod;
	logic [MAP_AW-1:0]  h_calc;
	logic               do_release;
	logic [KSEL_W-1:0]  rel_k;
	logic [IDX_W-1:0]   rel_idx;
	logic [KSEL_W-1:0]  cnt_k;

	logic               s_we, s_re;
	logic [SLOT_AW-1:0] s_waddr, s_raddr;
	logic [SLOT_W-1:0]  s_wdata, s_rdata;
	logic               f_we, f_re;
	logic [SLOT_AW-1:0] f_waddr, f_raddr;
	logic [IDX_W-1:0]   f_rdata;
	logic               fr_we, fr_re;
	logic [FRAME_AW-1:0] fr_waddr, fr_raddr;
	logic [IDX_W-1:0]   fr_rdata;
	logic               m_we, m_re;
	logic [MAP_AW-1:0]  m_waddr, m_raddr;
	logic [MAP_W-1:0]   m_wdata, m_rdata;
	logic               d_we, d_re;
	logic [VALUE_W-1:0] d_rdata;

	assign uop     = cmd.uop;
	assign op      = req_q.opcode;
	assign pool_k  = (op == OP_INTERN) ? KSEL_W'(KIND_COUNT - 1)
	                                   : KSEL_W'(req_q.ref_kind - 4'd1);
	assign tk      = req_q.token_in[TOKEN_W-1:KIND_SHIFT];
	assign ti      = req_q.token_in[KIND_SHIFT-1:0];
	assign tok_k   = KSEL_W'(tk - 4'd1);
	assign tok_idx = ti[IDX_W-1:0];
	assign cnt_k   = KSEL_W'(req_q.ref_kind - 4'd1);

	always_comb begin
		case (op)
			OP_RESOLVE: kind_ok = (tk >= KIND_LOCAL) && (tk <= KIND_ID);
			OP_DELETE:  kind_ok = (tk >= KIND_LOCAL) && (tk <= KIND_WEAK);
			default:    kind_ok = (tk == KIND_ID);
		endcase
	end

	assign take_idx = from_free_q ? f_rdata : hw_q[pool_k][IDX_W-1:0];

	// one shared multiplier, three partial products of the low product bits
	assign xs     = req_q.ref_value ^ (req_q.ref_value >> HASH_SH);
	assign mul_a  = (uop == UOP_HASH3) ? xs[ACC_W-1:LO_W] : HI_W'(xs[LO_W-1:0]);
	assign mul_b  = (uop == UOP_HASH2) ? HASH_C_HI : HASH_C_LO;
	assign prod   = mul_a * mul_b;
	assign h_calc = acc_q[MAP_AW-1:0] ^ acc_q[ACC_W-1:HASH_SH];

	assign do_release = ((uop == UOP_TOK_USE) && (op == OP_DELETE) && s_rdata[VALUE_W]) ||
	                    ((uop == UOP_POP_USE) && pop_ok_q && s_rdata[VALUE_W]);
	assign rel_k      = (uop == UOP_POP_USE) ? '0 : tok_k;
	assign rel_idx    = (uop == UOP_POP_USE) ? pop_idx_q : tok_idx;

	// memory ports
	assign s_we    = (uop == UOP_TAKE) || do_release;
	assign s_waddr = (uop == UOP_TAKE) ? {pool_k, take_idx} : {rel_k, rel_idx};
	assign s_wdata = (uop == UOP_TAKE) ? {1'b1, req_q.ref_value} : '0;
	assign s_re    = (uop == UOP_TOK_RD) || (uop == UOP_POP_CHK);
	assign s_raddr = (uop == UOP_POP_CHK) ? {KSEL_W'(0), fr_rdata} : {tok_k, tok_idx};

	assign f_we    = do_release && (fd_q[rel_k] < CNT_W'(POOL_DEPTH));
	assign f_waddr = {rel_k, fd_q[rel_k][IDX_W-1:0]};
	assign f_re    = (uop == UOP_FREE_RD);
	assign f_raddr = {pool_k, IDX_W'(fd_q[pool_k] - CNT_W'(1))};

	assign fr_we    = (uop == UOP_TAKE) && (pool_k == '0) &&
	                  (fdepth_q < FDEP_W'(FRAME_DEPTH));
	assign fr_waddr = fdepth_q[FRAME_AW-1:0];
	assign fr_re    = (uop == UOP_POP_RD);
	assign fr_raddr = FRAME_AW'(fdepth_q - FDEP_W'(1));

	assign m_we    = (uop == UOP_CLEAR) || ((uop == UOP_TAKE) && (op == OP_INTERN));
	assign m_waddr = (uop == UOP_CLEAR) ? clr_q : h_q;
	assign m_wdata = (uop == UOP_CLEAR) ? '0 : {req_q.ref_value, take_idx};
	assign m_re    = (uop == UOP_PROBE_RD) || (uop == UOP_PROBE_STEP);
	assign m_raddr = (uop == UOP_PROBE_STEP) ? MAP_AW'(h_q + MAP_AW'(1)) : h_calc;

	assign d_we = (uop == UOP_TAKE) && (op == OP_INTERN);
	assign d_re = (uop == UOP_TOK_RD);

	htt_ram #(.WIDTH(SLOT_W), .DEPTH(KIND_COUNT * POOL_DEPTH)) u_slot_ram (
		.clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.re(s_re), .raddr(s_raddr), .rdata(s_rdata)
	);

	htt_ram #(.WIDTH(IDX_W), .DEPTH(KIND_COUNT * POOL_DEPTH)) u_free_ram (
		.clk, .we(f_we), .waddr(f_waddr), .wdata(rel_idx),
		.re(f_re), .raddr(f_raddr), .rdata(f_rdata)
	);

	htt_ram #(.WIDTH(IDX_W), .DEPTH(FRAME_DEPTH)) u_frame_ram (
		.clk, .we(fr_we), .waddr(fr_waddr), .wdata(take_idx),
		.re(fr_re), .raddr(fr_raddr), .rdata(fr_rdata)
	);

	htt_ram #(.WIDTH(MAP_W), .DEPTH(MAP_DEPTH)) u_map_ram (
		.clk, .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.re(m_re), .raddr(m_raddr), .rdata(m_rdata)
	);

	htt_ram #(.WIDTH(VALUE_W), .DEPTH(POOL_DEPTH)) u_desc_ram (
		.clk, .we(d_we), .waddr(take_idx), .wdata(req_q.descriptor),
		.re(d_re), .raddr(tok_idx), .rdata(d_rdata)
	);

	// status
	assign stat.op        = op;
	assign stat.new_ok    = (req_q.ref_value != '0) && (req_q.ref_kind >= KIND_LOCAL) &&
	                        (req_q.ref_kind <= KIND_WEAK);
	assign stat.intern_ok = (req_q.ref_value != '0);
	assign stat.tok_ok    = kind_ok && (ti < KIND_SHIFT'(hw_q[tok_k]));
	assign stat.can_free  = (fd_q[pool_k] != '0);
	assign stat.can_fresh = (hw_q[pool_k] < CNT_W'(POOL_DEPTH));
	assign stat.map_empty = (m_rdata[MAP_W-1:IDX_W] == '0);
	assign stat.map_match = (m_rdata[MAP_W-1:IDX_W] == req_q.ref_value);
	assign stat.pop_more  = (fdepth_q > req_q.pop_mark);
	assign stat.clr_last  = (clr_q == MAP_AW'(MAP_DEPTH - 1));

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KIND_COUNT; i++) begin
				hw_q[i]   <= '0;
				fd_q[i]   <= '0;
				live_q[i] <= '0;
			end
			fdepth_q    <= '0;
			clr_q       <= '0;
			from_free_q <= 1'b0;
			pop_ok_q    <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= (uop == UOP_DONE);
			case (uop)
				UOP_LOAD:  from_free_q <= 1'b0;
				UOP_CLEAR: clr_q <= clr_q + MAP_AW'(1);
				UOP_FREE_RD: begin
					fd_q[pool_k] <= fd_q[pool_k] - CNT_W'(1);
					from_free_q  <= 1'b1;
				end
				UOP_TAKE: begin
					if (!from_free_q) hw_q[pool_k] <= hw_q[pool_k] + CNT_W'(1);
					live_q[pool_k] <= live_q[pool_k] + CNT_W'(1);
					if (fr_we) fdepth_q <= fdepth_q + FDEP_W'(1);
				end
				UOP_POP_RD:  fdepth_q <= fdepth_q - FDEP_W'(1);
				UOP_POP_CHK: pop_ok_q <= ({1'b0, fr_rdata} < hw_q[0]);
				default: ;
			endcase
			if (do_release) begin
				live_q[rel_k] <= live_q[rel_k] - CNT_W'(1);
				if (f_we) fd_q[rel_k] <= fd_q[rel_k] + CNT_W'(1);
			end
		end
	end

	// item payload and result
	always_ff @(posedge clk) begin
		case (uop)
			UOP_LOAD: begin
				req_q <= req;
				rsp_q <= '0;
			end
			UOP_HASH1: acc_q <= prod[ACC_W-1:0];
			UOP_HASH2, UOP_HASH3: acc_q <= acc_q + {prod[HI_W-1:0], LO_W'(0)};
			UOP_PROBE_RD:   h_q <= h_calc;
			UOP_PROBE_STEP: h_q <= h_q + MAP_AW'(1);
			UOP_MAP_HIT: rsp_q.token_out <= {KIND_ID, PAD_W'(0), m_rdata[IDX_W-1:0]};
			UOP_TAKE: rsp_q.token_out <= {KCODE_W'(pool_k) + KCODE_W'(1), PAD_W'(0), take_idx};
			UOP_TOK_USE: begin
				if (s_rdata[VALUE_W]) begin
					case (op)
						OP_RESOLVE: rsp_q.value_out <= s_rdata[VALUE_W-1:0];
						OP_ID_DESC: rsp_q.value_out <= d_rdata;
						default:    rsp_q.deleted   <= 1'b1;
					endcase
				end
			end
			UOP_POP_CHK: pop_idx_q <= fr_rdata;
			UOP_DONE: begin
				if (op == OP_FRAME_MARK) begin
					rsp_q.count_out <= COUNT_W'(fdepth_q);
				end else if ((op == OP_LIVE_COUNT) && (req_q.ref_kind >= KIND_LOCAL) &&
				             (req_q.ref_kind <= KIND_ID)) begin
					rsp_q.count_out <= COUNT_W'(live_q[cnt_k]);
				end
			end
			default: ;
		endcase
	end

	assign rsp  = rsp_q;
	assign done = done_q;

endmodule

### rtl/handle_token_table.sv
`timescale 1ns / 1ps
// Handle token table: maps 64-bit values to 32-bit tokens (kind in the top four
// bits, slot index below). Four kinds, each with a slot pool; the three non-ID
// pools reuse freed slots last-in first-out; local refs are also pushed on a
// frame stack, and IDs are deduplicated through a linear-probe hash map.
//
// Channels: drive req and raise start; the item is taken at a clock edge where
// start is high and busy is low. One result per item appears on rsp with done
// high for exactly one cycle; the receiver cannot hold it off, so capture it.
//
// Steps from accept to done: frame_mark, live_count and any item dropped at
// dispatch (null value, bad kind or token, full pool) go straight to done;
// resolve, delete and id_desc read the slot and then use it; new_ref takes a
// slot. intern_id hashes the value, then probes the map entry by entry until it
// finds the value or an empty entry, where it takes a slot if the pool has one.
// frame_pop reads, checks and releases entries one by one down to the mark. The
// next item is accepted on the cycle done is high, not before; the walks over
// the map and the frame stack are the longest items.
// Reset: counters and the controller clear at once, then all 2048 map entries
// are swept to empty, one entry a cycle, with busy held high.
module handle_token_table (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  htt_pkg::req_t  req,
	output logic          done,
	output htt_pkg::rsp_t  rsp
);
	import htt_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencer: one micro-operation per cycle
	htt_ctrl u_ctrl (
		.clk, .arst_n, .start, .stat, .cmd, .busy
	);

	// pools, frame stack, hash map and result register
	htt_dpath u_dpath (
		.clk, .arst_n, .req, .cmd, .stat, .rsp, .done
	);

endmodule
